/* rtl/core/anchor_box_delta_decoder_unit_defines.svh */
`ifndef ANCHOR_BOX_DELTA_DECODER_UNIT_DEFINES_SVH
`define ANCHOR_BOX_DELTA_DECODER_UNIT_DEFINES_SVH

// Assertion on aclk that is switched off while aresetn is low.
`define ABDD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion on aclk that also holds while reset is applied.
`define ABDD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/core/abdd_pkg.sv */
package abdd_pkg;

    localparam int COORD_W    = 32;
    localparam int DELTA_W    = 16;
    localparam int VAR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 4 * COORD_W + 4 * DELTA_W + 4 * VAR_W;
    localparam int OUT_DATA_W = 4 * COORD_W;

    // Register stages from input to output register.
    localparam int PIPE_DEPTH = 15;

    // Restoring division 2^44 / minimum scale, one quotient bit per cycle.
    localparam int DIV_BITS = 45;

    localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_NORMALIZED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_VAR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_VAR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_VAR_W    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_VAR_H    = 3'd6;

    localparam logic [1:0] VMODE_FIXED = 2'd0;
    localparam logic [1:0] VMODE_NONE  = 2'd1;
    localparam logic [1:0] VMODE_ITEM  = 2'd2;

    localparam logic [VAR_W-1:0] VAR_ONE = 16'd4096;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    // Taylor coefficients 1/n! in Q.30, index n.
    localparam logic [31:0] EXP_COEF [9] = '{
        32'd1073741824, 32'd1073741824, 32'd536870912, 32'd178956971, 32'd44739243,
        32'd8947849, 32'd1491308, 32'd213044, 32'd26631
    };

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_NORM
    } div_state_t;

    // Mode and clamp bounds shared by both axis lanes.
    typedef struct packed {
        logic               torch;
        logic               add_one;
        logic [27:0]        lo_v;
        logic [44:0]        hi_v;
        logic [28:0]        lo_m;
        logic signed [9:0]  lo_e;
        logic [28:0]        hi_m;
        logic signed [9:0]  hi_e;
    } ctl_t;

    function automatic logic [31:0] sat32(input logic signed [47:0] v);
        logic [31:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/abdd_axis.sv */
module abdd_axis (
    input  logic                 aclk,
    input  logic                 ce,
    input  abdd_pkg::ctl_t       ctl,
    input  logic signed [31:0]   lo_i,
    input  logic signed [31:0]   hi_i,
    input  logic signed [15:0]   dc_i,
    input  logic signed [15:0]   ds_i,
    input  logic [15:0]          vc_i,
    input  logic [15:0]          vs_i,
    output logic [31:0]          out_lo_o,
    output logic [31:0]          out_hi_o
);

    localparam int NH = 8;

    typedef struct packed {
        logic signed [47:0] ctr;
        logic signed [33:0] w;
        logic signed [9:0]  k;
        logic [29:0]        x;
    } hcarry_t;

    // Stage 1: size, center, both variance products.
    logic signed [33:0] lo_x, hi_x, sum_x;
    logic signed [33:0] w_next, c_next, w1_reg, c1_reg;
    logic signed [32:0] dpos_next, dsz_next, dpos_reg, dsz_reg;

    assign lo_x  = {{2{lo_i[31]}}, lo_i};
    assign hi_x  = {{2{hi_i[31]}}, hi_i};
    assign sum_x = hi_x + lo_x;
    assign w_next = hi_x - lo_x + (ctl.add_one ? 34'sd65536 : 34'sd0);
    assign c_next = ctl.torch ? (sum_x >>> 1) : (lo_x + (w_next >>> 1));
    assign dpos_next = $signed({1'b0, vc_i}) * dc_i;
    assign dsz_next  = $signed({1'b0, vs_i}) * ds_i;

    always_ff @(posedge aclk) begin
        if (ce) begin
            w1_reg   <= w_next;
            c1_reg   <= c_next;
            dpos_reg <= dpos_next;
            dsz_reg  <= dsz_next;
        end
    end

    // Stage 2: rounded center delta, log2 conversion of the size delta.
    logic signed [32:0] dpos_rnd;
    logic signed [24:0] r1_next, r1_reg;
    logic signed [63:0] tprod_next, tprod_reg;
    logic signed [33:0] w2_reg, c2_reg;

    assign dpos_rnd   = dpos_reg + 33'sd128;
    assign r1_next    = dpos_rnd[32:8];
    assign tprod_next = dsz_reg * $signed({1'b0, abdd_pkg::LOG2E_Q30});

    always_ff @(posedge aclk) begin
        if (ce) begin
            r1_reg    <= r1_next;
            tprod_reg <= tprod_next;
            w2_reg    <= w1_reg;
            c2_reg    <= c1_reg;
        end
    end

    // Stage 3: center shift product, fraction back to natural log.
    logic [33:0]        t_bits;
    logic signed [9:0]  k_next, k3_reg;
    logic [53:0]        xprod_next, xprod_reg;
    logic signed [58:0] sprod_next, sprod_reg;
    logic signed [33:0] w3_reg, c3_reg;

    assign t_bits     = tprod_reg[63:30];
    assign k_next     = t_bits[33:24];
    assign xprod_next = t_bits[23:0] * abdd_pkg::LN2_Q30;
    assign sprod_next = r1_reg * w2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            k3_reg    <= k_next;
            xprod_reg <= xprod_next;
            sprod_reg <= sprod_next;
            w3_reg    <= w2_reg;
            c3_reg    <= c2_reg;
        end
    end

    // Stages 4 to 11: one Horner step of the exp series per stage.
    logic signed [58:0] sh_rnd;
    logic signed [42:0] shift43;
    hcarry_t            hc_in;

    assign sh_rnd      = sprod_reg + 59'sd32768;
    assign shift43     = sh_rnd[58:16];
    assign hc_in.ctr   = {{14{c3_reg[33]}}, c3_reg} + {{5{shift43[42]}}, shift43};
    assign hc_in.w     = w3_reg;
    assign hc_in.k     = k3_reg;
    assign hc_in.x     = xprod_reg[53:24];

    hcarry_t     hc_reg [NH];
    logic [31:0] hp_reg [NH];

    for (genvar j = 0; j < NH; j++) begin : g_horner
        hcarry_t     c_in;
        logic [31:0] p_in;
        logic [61:0] prod;
        logic [31:0] p_next;

        if (j == 0) begin : g_first
            assign c_in = hc_in;
            assign p_in = abdd_pkg::EXP_COEF[NH];
        end else begin : g_rest
            assign c_in = hc_reg[j-1];
            assign p_in = hp_reg[j-1];
        end

        assign prod   = p_in * c_in.x;
        assign p_next = abdd_pkg::EXP_COEF[NH-1-j] + prod[61:30];

        always_ff @(posedge aclk) begin
            if (ce) begin
                hc_reg[j] <= c_in;
                hp_reg[j] <= p_next;
            end
        end
    end

    // Stage 12: mantissa and exponent, clamped in torch mode.
    hcarry_t            hl;
    logic [28:0]        m;
    logic signed [9:0]  negk;
    logic [45:0]        v;
    logic               in_range, hi_sel, lo_sel;
    logic [28:0]        mm;
    logic [28:0]        m_next, m12_reg;
    logic signed [9:0]  e_next, e12_reg;
    logic signed [47:0] ctr12_reg;
    logic signed [33:0] w12_reg;

    assign hl       = hc_reg[NH-1];
    assign m        = hp_reg[NH-1][30:2];
    assign negk     = -hl.k;
    assign in_range = (hl.k >= -10'sd29) && (hl.k <= 10'sd16);
    assign v        = hl.k[9] ? ({17'd0, m} >> negk[4:0]) : ({17'd0, m} << hl.k[4:0]);
    assign mm       = hl.k[9] ? ((m >> negk[4:0]) << negk[4:0]) : m;
    assign hi_sel   = (hl.k >= 10'sd17) || (in_range && (v > {1'b0, ctl.hi_v}));
    assign lo_sel   = (hl.k <= -10'sd30) || (in_range && (v < {18'd0, ctl.lo_v}));

    always_comb begin
        m_next = m;
        e_next = hl.k;
        if (ctl.torch) begin
            priority if (hi_sel) begin
                m_next = ctl.hi_m;
                e_next = ctl.hi_e;
            end else if (lo_sel) begin
                m_next = ctl.lo_m;
                e_next = ctl.lo_e;
            end else begin
                m_next = mm;
                e_next = hl.k;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m12_reg   <= m_next;
            e12_reg   <= e_next;
            ctr12_reg <= hl.ctr;
            w12_reg   <= hl.w;
        end
    end

    // Stage 13: size magnitude times scale mantissa.
    logic [33:0]        aw;
    logic [62:0]        p2_next, p2_reg;
    logic signed [10:0] ee_next, ee_reg;
    logic               neg13_reg;
    logic signed [47:0] ctr13_reg;

    assign aw      = w12_reg[33] ? 34'(-w12_reg) : 34'(w12_reg);
    assign p2_next = aw * m12_reg;
    assign ee_next = {e12_reg[9], e12_reg} - 11'sd29;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p2_reg    <= p2_next;
            ee_reg    <= ee_next;
            neg13_reg <= w12_reg[33];
            ctr13_reg <= ctr12_reg;
        end
    end

    // Stage 14: binary scaling, round half away from zero, saturate at 2^40.
    localparam logic [40:0] LIMIT = 41'h100_0000_0000;

    logic [40:0]        r;
    logic signed [47:0] h_next, h14_reg;
    logic signed [47:0] ctr14_reg;

    always_comb begin
        logic [62:0]        lim;
        logic [62:0]        shl;
        logic signed [10:0] s;
        logic [5:0]         sm1;
        logic [63:0]        q;
        r   = '0;
        lim = '0;
        shl = '0;
        s   = -ee_reg;
        sm1 = s[5:0] - 6'd1;
        q   = '0;
        if (p2_reg == 63'd0) begin
            r = '0;
        end else if (!ee_reg[10]) begin
            if (ee_reg >= 11'sd40) begin
                r = LIMIT;
            end else begin
                lim = {22'd0, LIMIT} >> ee_reg[5:0];
                shl = p2_reg << ee_reg[5:0];
                r   = (p2_reg > lim) ? LIMIT : shl[40:0];
            end
        end else if (s >= 11'sd64) begin
            r = '0;
        end else begin
            q = (({1'b0, p2_reg} >> sm1) + 64'd1) >> 1;
            r = (q > {23'd0, LIMIT}) ? LIMIT : q[40:0];
        end
    end

    assign h_next = neg13_reg ? -$signed({7'd0, r}) : $signed({7'd0, r});

    always_ff @(posedge aclk) begin
        if (ce) begin
            h14_reg   <= h_next;
            ctr14_reg <= ctr13_reg;
        end
    end

    // Stage 15: corners and output saturation.
    logic signed [47:0] lo_off, hi_off;
    logic [31:0]        out_lo_reg, out_hi_reg;

    always_comb begin
        if (ctl.torch) begin
            lo_off = 48'sd32768;
            hi_off = -48'sd32768;
        end else begin
            lo_off = 48'sd0;
            hi_off = ctl.add_one ? -48'sd65536 : 48'sd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_lo_reg <= abdd_pkg::sat32(ctr14_reg - h14_reg + lo_off);
            out_hi_reg <= abdd_pkg::sat32(ctr14_reg + h14_reg + hi_off);
        end
    end

    assign out_lo_o = out_lo_reg;
    assign out_hi_o = out_hi_reg;

endmodule

/* rtl/core/anchor_box_delta_decoder_unit.sv */
// Decodes one anchor box and its deltas into one box per item, x and y in two
// parallel lanes of a 15-stage pipeline (eight of the stages evaluate the exp series).
// One item is taken per cycle while s_tready is high. A stall on the result side
// holds the whole pipeline. Writing a nonzero minimum scale starts a bound
// computation (a bit-serial division, then normalization of both bounds) during
// which s_tready stays low; other writes take effect at once.
module anchor_box_delta_decoder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // anchor_x0, anchor_y0, anchor_x1, anchor_y1, delta_x, delta_y, delta_w,
    // delta_h, item_var_x, item_var_y, item_var_w, item_var_h
    input  logic [abdd_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_x0, out_y0, out_x1, out_y1
    output logic [abdd_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [abdd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [abdd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Configuration registers.
    logic [1:0]  vmode_reg;
    logic        box_norm_reg;
    logic [15:0] min_reg;
    logic [15:0] fvar_x_reg, fvar_y_reg, fvar_w_reg, fvar_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vmode_reg    <= abdd_pkg::VMODE_NONE;
            box_norm_reg <= 1'b1;
            min_reg      <= '0;
            fvar_x_reg   <= abdd_pkg::VAR_ONE;
            fvar_y_reg   <= abdd_pkg::VAR_ONE;
            fvar_w_reg   <= abdd_pkg::VAR_ONE;
            fvar_h_reg   <= abdd_pkg::VAR_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                abdd_pkg::REG_VARIANCE_MODE:  vmode_reg    <= cfg_wdata[1:0];
                abdd_pkg::REG_BOX_NORMALIZED: box_norm_reg <= cfg_wdata[0];
                abdd_pkg::REG_SCALE_FLOOR:    min_reg      <= cfg_wdata;
                abdd_pkg::REG_FIXED_VAR_X:    fvar_x_reg   <= cfg_wdata;
                abdd_pkg::REG_FIXED_VAR_Y:    fvar_y_reg   <= cfg_wdata;
                abdd_pkg::REG_FIXED_VAR_W:    fvar_w_reg   <= cfg_wdata;
                abdd_pkg::REG_FIXED_VAR_H:    fvar_h_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp bound sequencer: upper bound 2^44 / min, both bounds normalized.
    abdd_pkg::div_state_t state_reg, state_next;
    logic              min_wr, start;
    logic              busy, run_en, norm_en;
    logic [16:0]       rem_reg;
    logic [44:0]       quo_reg;
    logic [5:0]        cnt_reg;
    logic [44:0]       hm_reg;
    logic signed [9:0] he_reg;
    logic [28:0]       lm_reg;
    logic signed [9:0] le_reg;
    logic              hm_big, lm_small;
    logic [16:0]       rem_shift;
    logic              qbit;
    logic [16:0]       rem_next;
    logic [44:0]       quo_next;

    assign min_wr   = cfg_wr_en && (cfg_index == abdd_pkg::REG_SCALE_FLOOR);
    assign start    = min_wr && (cfg_wdata != '0);
    assign hm_big   = hm_reg >= 45'h2000_0000;
    assign lm_small = lm_reg < 29'h1000_0000;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            abdd_pkg::DIV_IDLE: begin
                if (start) state_next = abdd_pkg::DIV_RUN;
            end
            abdd_pkg::DIV_RUN: begin
                priority if (min_wr) state_next = start ? abdd_pkg::DIV_RUN : abdd_pkg::DIV_IDLE;
                else if (cnt_reg == 6'd0) state_next = abdd_pkg::DIV_NORM;
            end
            abdd_pkg::DIV_NORM: begin
                priority if (min_wr) state_next = start ? abdd_pkg::DIV_RUN : abdd_pkg::DIV_IDLE;
                else if (!hm_big && !lm_small) state_next = abdd_pkg::DIV_IDLE;
            end
            default: state_next = abdd_pkg::DIV_IDLE;
        endcase
    end

    always_comb begin
        busy    = state_reg != abdd_pkg::DIV_IDLE;
        run_en  = state_reg == abdd_pkg::DIV_RUN;
        norm_en = state_reg == abdd_pkg::DIV_NORM;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= abdd_pkg::DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The dividend is a single one at its top bit.
    assign rem_shift = {rem_reg[15:0], cnt_reg == 6'(abdd_pkg::DIV_BITS - 1)};
    assign qbit      = rem_shift >= {1'b0, min_reg};
    assign rem_next  = qbit ? (rem_shift - {1'b0, min_reg}) : rem_shift;
    assign quo_next  = {quo_reg[43:0], qbit};

    always_ff @(posedge aclk) begin
        if (min_wr) begin
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= 6'(abdd_pkg::DIV_BITS - 1);
        end else if (run_en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                hm_reg <= quo_next;
                he_reg <= '0;
                lm_reg <= {1'b0, min_reg, 12'd0};
                le_reg <= '0;
            end
        end else if (norm_en) begin
            if (hm_big) begin
                hm_reg <= hm_reg >> 1;
                he_reg <= he_reg + 10'sd1;
            end
            if (lm_small) begin
                lm_reg <= lm_reg << 1;
                le_reg <= le_reg - 10'sd1;
            end
        end
    end

    abdd_pkg::ctl_t ctl;

    assign ctl.torch   = min_reg != '0;
    assign ctl.add_one = (min_reg != '0) || !box_norm_reg;
    assign ctl.lo_v    = {min_reg, 12'd0};
    assign ctl.hi_v    = quo_reg;
    assign ctl.lo_m    = lm_reg;
    assign ctl.lo_e    = le_reg;
    assign ctl.hi_m    = hm_reg[28:0];
    assign ctl.hi_e    = he_reg;

    // Pipeline control: the whole pipeline advances unless the output is stalled.
    logic                           ce;
    logic                           s_acc;
    logic [abdd_pkg::PIPE_DEPTH-1:0] vld_reg, vld_next;

    assign ce       = !vld_reg[abdd_pkg::PIPE_DEPTH-1] || m_tready;
    assign s_tready = ce && !busy;
    assign s_acc    = s_tvalid && s_tready;
    assign vld_next = {vld_reg[abdd_pkg::PIPE_DEPTH-2:0], s_acc};
    assign m_tvalid = vld_reg[abdd_pkg::PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end

    // Variance selection.
    logic [15:0] vx, vy, vw, vh;

    always_comb begin
        unique case (vmode_reg)
            abdd_pkg::VMODE_FIXED: begin
                vx = fvar_x_reg;
                vy = fvar_y_reg;
                vw = fvar_w_reg;
                vh = fvar_h_reg;
            end
            abdd_pkg::VMODE_ITEM: begin
                vx = s_tdata[207:192];
                vy = s_tdata[223:208];
                vw = s_tdata[239:224];
                vh = s_tdata[255:240];
            end
            default: begin
                vx = abdd_pkg::VAR_ONE;
                vy = abdd_pkg::VAR_ONE;
                vw = abdd_pkg::VAR_ONE;
                vh = abdd_pkg::VAR_ONE;
            end
        endcase
    end

    logic [31:0] out_x0, out_y0, out_x1, out_y1;

    abdd_axis u_axis_x (
        .aclk     (aclk),
        .ce       (ce),
        .ctl      (ctl),
        .lo_i     ($signed(s_tdata[31:0])),
        .hi_i     ($signed(s_tdata[95:64])),
        .dc_i     ($signed(s_tdata[143:128])),
        .ds_i     ($signed(s_tdata[175:160])),
        .vc_i     (vx),
        .vs_i     (vw),
        .out_lo_o (out_x0),
        .out_hi_o (out_x1)
    );

    abdd_axis u_axis_y (
        .aclk     (aclk),
        .ce       (ce),
        .ctl      (ctl),
        .lo_i     ($signed(s_tdata[63:32])),
        .hi_i     ($signed(s_tdata[127:96])),
        .dc_i     ($signed(s_tdata[159:144])),
        .ds_i     ($signed(s_tdata[191:176])),
        .vc_i     (vy),
        .vs_i     (vh),
        .out_lo_o (out_y0),
        .out_hi_o (out_y1)
    );

    assign m_tdata = {out_y1, out_x1, out_y0, out_x0};

endmodule

/* rtl/core/abdd_checker.sv */
`include "anchor_box_delta_decoder_unit_defines.svh"

module abdd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [abdd_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                             cfg_wr_en,
    input logic [abdd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [abdd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic out_stall;
    logic floor_start;

    assign out_stall   = m_tvalid && !m_tready;
    assign floor_start = cfg_wr_en && (cfg_index == abdd_pkg::REG_SCALE_FLOOR)
                         && (cfg_wdata != '0);

    // A stalled result item holds its value.
    `ABDD_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // Reset empties the pipeline.
    `ABDD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result item after reset")

    // A new nonzero minimum scale blocks input while the bounds are recomputed.
    `ABDD_ASSERT(a_bound_busy, floor_start |=> !s_tready, "input taken during bound computation")

endmodule

bind anchor_box_delta_decoder_unit abdd_checker u_abdd_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic signed [31:0] ax0, ay0, ax1, ay1;
        logic signed [15:0] dx, dy, dw, dh;
        logic [15:0]        vx, vy, vw, vh;
    } anchor_item_t;

    typedef struct {
        logic [31:0] x0, y0, x1, y1;
    } box_t;

    typedef struct {
        anchor_item_t item;
        bit           known;
        box_t         box;
    } row_t;

    localparam longint HALF_CAP  = 64'd1 << 40;
    localparam longint ONE_Q16   = 65536;
    localparam longint HALF_Q16  = 32768;
    localparam int     STALL_LIMIT = 20000;
    // Index that maps to no register.
    localparam logic [abdd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [abdd_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [abdd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [abdd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [abdd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the register file.
    logic [1:0]  sh_mode = abdd_pkg::VMODE_NONE;
    logic        sh_norm = 1'b1;
    logic [15:0] sh_min = 16'd0;
    logic [15:0] sh_fvx = abdd_pkg::VAR_ONE, sh_fvy = abdd_pkg::VAR_ONE;
    logic [15:0] sh_fvw = abdd_pkg::VAR_ONE, sh_fvh = abdd_pkg::VAR_ONE;

    box_t pending_boxes[$];
    int   fails = 0;
    int   snd_idle = 31, rcv_idle = 77;
    int   hold_req = 0, hold_done = 0, hold_left = 0;
    int   quiet_cycles = 0;

    anchor_box_delta_decoder_unit uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint sat_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // exp(d) for d in Q8.24: mantissa in Q.28 and binary exponent.
    function automatic void exp_q(longint d, output longint m, output longint k);
        longint t, f, x, p;
        t = (d * 64'sd1549082005) >>> 30;
        f = t & 64'hFFFFFF;
        x = (f * 64'sd744261118) >> 24;
        p = abdd_pkg::EXP_COEF[8];
        for (int i = 7; i >= 0; i--) begin
            p = longint'(abdd_pkg::EXP_COEF[i]) + ((p * x) >> 30);
        end
        m = p >> 2;
        k = t >>> 24;
    endfunction

    function automatic longint scale_half(longint w, longint m, longint e);
        longint a, p, r;
        a = (w < 0) ? -w : w;
        p = a * m;
        if (p == 0) r = 0;
        else if (e >= 0) r = (e >= 40 || p > (HALF_CAP >> e)) ? HALF_CAP : (p << e);
        else begin
            if (-e >= 64) r = 0;
            else r = (p >> (-e)) + ((p >> (-e - 1)) & 1);
            if (r > HALF_CAP) r = HALF_CAP;
        end
        return (w < 0) ? -r : r;
    endfunction

    function automatic void decode_edge(longint lo, longint hi, longint dc, longint ds,
                                        longint vc, longint vs, bit torch, longint one,
                                        output logic [31:0] o_lo, output logic [31:0] o_hi);
        longint w, c, ctr, m, k, h, lo_b, hi_b, v, e;
        w = hi - lo + one;
        c = torch ? ((lo + hi) >>> 1) : lo + (w >>> 1);
        ctr = c + (((((vc * dc) + 128) >>> 8) * w + 32768) >>> 16);
        exp_q(vs * ds, m, k);
        if (torch) begin
            lo_b = longint'(sh_min) << 12;
            hi_b = (64'd1 << 44) / longint'(sh_min);
            if (k >= 17) v = hi_b;
            else if (k <= -30) v = lo_b;
            else begin
                v = (k >= 0) ? (m << k) : (m >> (-k));
                if (v > hi_b) v = hi_b;
                if (v < lo_b) v = lo_b;
            end
            e = 0;
            while (v >= (64'd1 << 29)) begin v = v >> 1; e++; end
            while (v < (64'd1 << 28)) begin v = v << 1; e--; end
            m = v;
            k = e;
        end
        h = scale_half(w, m, k - 29);
        if (torch) begin
            o_lo = 32'(sat_coord(ctr - h + HALF_Q16));
            o_hi = 32'(sat_coord(ctr + h - HALF_Q16));
        end else begin
            o_lo = 32'(sat_coord(ctr - h));
            o_hi = 32'(sat_coord(ctr + h - one));
        end
    endfunction

    function automatic box_t decode_box(anchor_item_t it);
        box_t b;
        bit torch;
        longint one;
        logic [15:0] vx, vy, vw, vh;
        torch = sh_min != 0;
        one = (torch || !sh_norm) ? ONE_Q16 : 0;
        {vx, vy, vw, vh} = {4{abdd_pkg::VAR_ONE}};
        if (sh_mode == abdd_pkg::VMODE_FIXED) begin
            {vx, vy, vw, vh} = {sh_fvx, sh_fvy, sh_fvw, sh_fvh};
        end else if (sh_mode == abdd_pkg::VMODE_ITEM) begin
            {vx, vy, vw, vh} = {it.vx, it.vy, it.vw, it.vh};
        end
        decode_edge(longint'(it.ax0), longint'(it.ax1), longint'(it.dx), longint'(it.dw),
                    longint'(vx), longint'(vw), torch, one, b.x0, b.x1);
        decode_edge(longint'(it.ay0), longint'(it.ay1), longint'(it.dy), longint'(it.dh),
                    longint'(vy), longint'(vh), torch, one, b.y0, b.y1);
        return b;
    endfunction

    function automatic anchor_item_t mk(int ax0, int ay0, int ax1, int ay1,
                                        int dx, int dy, int dw, int dh, int v);
        anchor_item_t it;
        it.ax0 = ax0; it.ay0 = ay0; it.ax1 = ax1; it.ay1 = ay1;
        it.dx = 16'(dx); it.dy = 16'(dy); it.dw = 16'(dw); it.dh = 16'(dh);
        it.vx = 16'(v); it.vy = 16'(v); it.vw = 16'(v); it.vh = 16'(v);
        return it;
    endfunction

    function automatic logic signed [15:0] rand_delta();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 16383) - 8192);
    endfunction

    function automatic logic [15:0] rand_var();
        if ($urandom_range(0, 2) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 8192));
    endfunction

    function automatic anchor_item_t rand_item();
        anchor_item_t it;
        if ($urandom_range(0, 9) == 0) begin
            it.ax0 = $urandom; it.ay0 = $urandom; it.ax1 = $urandom; it.ay1 = $urandom;
        end else begin
            it.ax0 = $urandom_range(0, 640 << 16) - (64 << 16);
            it.ay0 = $urandom_range(0, 480 << 16) - (64 << 16);
            it.ax1 = it.ax0 + $urandom_range(0, 300 << 16) - (8 << 16);
            it.ay1 = it.ay0 + $urandom_range(0, 300 << 16) - (8 << 16);
        end
        it.dx = rand_delta(); it.dy = rand_delta(); it.dw = rand_delta(); it.dh = rand_delta();
        it.vx = rand_var(); it.vy = rand_var(); it.vw = rand_var(); it.vh = rand_var();
        return it;
    endfunction

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(logic [abdd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            abdd_pkg::REG_VARIANCE_MODE:  sh_mode = val[1:0];
            abdd_pkg::REG_BOX_NORMALIZED: sh_norm = val[0];
            abdd_pkg::REG_SCALE_FLOOR:    sh_min = val;
            abdd_pkg::REG_FIXED_VAR_X:    sh_fvx = val;
            abdd_pkg::REG_FIXED_VAR_Y:    sh_fvy = val;
            abdd_pkg::REG_FIXED_VAR_W:    sh_fvw = val;
            abdd_pkg::REG_FIXED_VAR_H:    sh_fvh = val;
            default: ;
        endcase
    endtask

    task automatic send_box(anchor_item_t it, bit known, box_t want);
        s_tvalid <= 1'b1;
        s_tdata <= {it.vh, it.vw, it.vy, it.vx, it.dh, it.dw, it.dy, it.dx,
                    it.ay1, it.ax1, it.ay0, it.ax0};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_boxes.push_back(known ? want : decode_box(it));
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Pipeline is 15 deep; leave margin before touching registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending_boxes.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_side
        box_t want;
        box_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.x0 = m_tdata[31:0];
                got.y0 = m_tdata[63:32];
                got.x1 = m_tdata[95:64];
                got.y1 = m_tdata[127:96];
                if (pending_boxes.size() == 0) begin
                    $error("unexpected result item %h", m_tdata);
                    fails++;
                end else begin
                    want = pending_boxes.pop_front();
                    if (got.x0 !== want.x0) begin
                        $error("out_x0 expected %h actual %h", want.x0, got.x0); fails++;
                    end
                    if (got.y0 !== want.y0) begin
                        $error("out_y0 expected %h actual %h", want.y0, got.y0); fails++;
                    end
                    if (got.x1 !== want.x1) begin
                        $error("out_x1 expected %h actual %h", want.x1, got.x1); fails++;
                    end
                    if (got.y1 !== want.y1) begin
                        $error("out_y1 expected %h actual %h", want.y1, got.y1); fails++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (hold_req != hold_done) begin
                hold_done <= hold_req;
                hold_left <= 300;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("anchor_box_delta_decoder_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        row_t rows[$];
        row_t r;
        box_t zero_box;
        zero_box = '{default: '0};

        r.known = 1'b1;
        r.item = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.box = zero_box;
        rows.push_back(r);
        r.item = mk(0, 0, 65536, 65536, 0, 0, 0, 0, 4096);
        r.box = '{32'd0, 32'd0, 32'd65536, 32'd65536};
        rows.push_back(r);
        // Full-range anchor: the low corners saturate, the high corners reach the largest value.
        r.item = mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        r.box = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        rows.push_back(r);
        r.known = 1'b0;
        r.item = mk(0, 0, 65536, 65536, 32767, 32767, 32767, 32767, 65535);
        rows.push_back(r);
        r.item = mk(0, 0, 65536, 65536, -32768, -32768, -32768, -32768, 0);
        rows.push_back(r);
        r.item = mk(10 << 16, 20 << 16, 2 << 16, 5 << 16, 2048, -2048, 1000, -1000, 4096);
        rows.push_back(r);
        r.item = mk(32'h8000_0000, -5, 32'h7FFF_FFFF, 5, 100, -100, 32767, -32768, 0);
        rows.push_back(r);
        r.item = mk(-1, -1, -1, -1, -1, -1, -1, -1, 65535);
        rows.push_back(r);
        r.item = mk(100 << 16, 50 << 16, 164 << 16, 90 << 16, 409, -409, 4096, -4096, 1);
        rows.push_back(r);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_box(rows[i].item, rows[i].known, rows[i].box);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(abdd_pkg::REG_VARIANCE_MODE, abdd_pkg::VMODE_FIXED);
                    write_reg(abdd_pkg::REG_BOX_NORMALIZED, 16'd0);
                    write_reg(abdd_pkg::REG_FIXED_VAR_X, 16'd0);
                    write_reg(abdd_pkg::REG_FIXED_VAR_Y, 16'hFFFF);
                    write_reg(abdd_pkg::REG_FIXED_VAR_W, 16'd1234);
                    write_reg(abdd_pkg::REG_FIXED_VAR_H, abdd_pkg::VAR_ONE);
                end
                1: begin
                    write_reg(abdd_pkg::REG_VARIANCE_MODE, abdd_pkg::VMODE_ITEM);
                    write_reg(abdd_pkg::REG_BOX_NORMALIZED, 16'd1);
                end
                2: begin
                    // All ones: variance mode becomes the unused code.
                    write_reg(abdd_pkg::REG_VARIANCE_MODE, 16'hFFFF);
                    write_reg(abdd_pkg::REG_BOX_NORMALIZED, 16'hFFFF);
                    write_reg(abdd_pkg::REG_SCALE_FLOOR, 16'd1);
                end
                3: begin
                    write_reg(abdd_pkg::REG_VARIANCE_MODE, abdd_pkg::VMODE_ITEM);
                    write_reg(abdd_pkg::REG_SCALE_FLOOR, 16'hFFFF);
                end
                4: begin
                    write_reg(abdd_pkg::REG_VARIANCE_MODE, abdd_pkg::VMODE_FIXED);
                    write_reg(abdd_pkg::REG_SCALE_FLOOR, 16'd32768);
                    write_reg(abdd_pkg::REG_FIXED_VAR_X, 16'($urandom));
                    write_reg(abdd_pkg::REG_FIXED_VAR_Y, 16'($urandom));
                    write_reg(abdd_pkg::REG_FIXED_VAR_W, 16'($urandom_range(0, 8192)));
                    write_reg(abdd_pkg::REG_FIXED_VAR_H, 16'($urandom_range(0, 8192)));
                end
                5: begin
                    write_reg(abdd_pkg::REG_VARIANCE_MODE, abdd_pkg::VMODE_ITEM);
                    write_reg(abdd_pkg::REG_BOX_NORMALIZED, 16'd0);
                    write_reg(abdd_pkg::REG_SCALE_FLOOR, 16'd0);
                    write_reg(REG_UNUSED, 16'($urandom));
                end
                default: begin
                    write_reg(abdd_pkg::REG_VARIANCE_MODE, abdd_pkg::VMODE_NONE);
                    write_reg(abdd_pkg::REG_SCALE_FLOOR, 16'($urandom_range(1, 65535)));
                end
            endcase
            cfg_wr_en <= 1'b0;
            if (ph < 2) begin
                snd_idle = 31; rcv_idle = 77;
            end else if (ph < 4) begin
                snd_idle = 77; rcv_idle = 31;
            end else begin
                snd_idle = 0; rcv_idle = 0;
            end
            // Long result-side stall while items keep coming in.
            if (ph == 4) hold_req++;
            for (int n = 0; n < 78; n++) send_box(rand_item(), 1'b0, zero_box);
            drain();
        end

        if (fails == 0) begin
            $display("anchor_box_delta_decoder_unit test passed");
        end else begin
            $display("anchor_box_delta_decoder_unit test failed");
        end
        $finish;
    end

endmodule
